[src/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent implies consequent on the next clock edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// arpc_pkg
// types and constants shared by the arp cache table engine
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

    localparam int DEF_ENTRIES = 64;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int OP_W  = 16;
    localparam int ENT_W = IP_W + MAC_W;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_PACKET = 2'd2;
    localparam logic [1:0] REQ_RSVD   = 2'd3;

    localparam logic [OP_W-1:0] OPC_REQUEST = 16'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN_ADDR,
        S_SCAN_CMP,
        S_WRITE,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic load;
        logic inc_idx;
        logic set_found;
        logic wr_en;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_lookup;
        logic is_rsvd;
        logic count_zero;
        logic idx_last;
        logic match;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

[src/arpc_ram.sv]
// ----------------------------------------------------------------------------
// arpc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/arpc_ctrl.sv]
// ----------------------------------------------------------------------------
// arpc_ctrl
// request sequencer: match scan, table write and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire arpc_pkg::t_dp_sts i_sts,
    output arpc_pkg::t_dp_cmd      o_cmd
);

    import arpc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_sts.is_rsvd) begin
                    n_state = S_RESULT;
                end else if (i_sts.count_zero) begin
                    n_state = i_sts.is_lookup ? S_RESULT : S_WRITE;
                end else begin
                    n_state = S_SCAN_ADDR;
                end
            end
            S_SCAN_ADDR: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_sts.match) begin
                    o_cmd.set_found = 1'b1;
                    n_state = i_sts.is_lookup ? S_RESULT : S_WRITE;
                end else if (i_sts.idx_last) begin
                    n_state = i_sts.is_lookup ? S_RESULT : S_WRITE;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state       = S_SCAN_ADDR;
                end
            end
            S_WRITE: begin
                o_cmd.wr_en = 1'b1;
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/arpc_dp.sv]
// ----------------------------------------------------------------------------
// arpc_dp
// request registers, scan index, fill count, table ram and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module arpc_dp #(
    parameter int ENTRIES = arpc_pkg::DEF_ENTRIES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [arpc_pkg::IP_W-1:0]   i_cfg_wr_data,
    input  wire logic [1:0]                  i_req_type,
    input  wire logic [arpc_pkg::IP_W-1:0]   i_ip_addr,
    input  wire logic [arpc_pkg::MAC_W-1:0]  i_hw_addr,
    input  wire logic [arpc_pkg::OP_W-1:0]   i_arp_opcode,
    input  wire logic [arpc_pkg::IP_W-1:0]   i_packet_target_ip,
    input  wire arpc_pkg::t_dp_cmd           i_cmd,
    output arpc_pkg::t_dp_sts                o_sts,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_hit,
    output logic [arpc_pkg::MAC_W-1:0]       o_found_mac,
    output logic                             o_reply_valid,
    output logic [arpc_pkg::IP_W-1:0]        o_reply_ip,
    output logic [arpc_pkg::MAC_W-1:0]       o_reply_mac
);

    import arpc_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    logic [IP_W-1:0]  r_local_ip;
    logic [1:0]       r_type;
    logic [IP_W-1:0]  r_ip;
    logic [MAC_W-1:0] r_mac;
    logic             r_reply;
    logic [AW-1:0]    r_idx;
    logic [CW-1:0]    r_count;
    logic             r_found;
    logic [MAC_W-1:0] r_found_mac;

    logic             r_out_valid;
    logic             r_hit;
    logic [MAC_W-1:0] r_o_found_mac;
    logic             r_o_reply;
    logic [IP_W-1:0]  r_o_reply_ip;
    logic [MAC_W-1:0] r_o_reply_mac;

    logic [ENT_W-1:0] rd_data;
    logic [AW-1:0]    wr_addr;
    logic             full;
    logic             out_free;
    logic             is_lookup;

    assign full      = (r_count == FULL_CNT);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign is_lookup = (r_type == REQ_LOOKUP);
    assign wr_addr   = r_found ? r_idx : (full ? '0 : r_count[AW-1:0]);

    arpc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (wr_addr),
        .i_wdata ({r_ip, r_mac}),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    always_comb begin
        o_sts.is_lookup  = is_lookup;
        o_sts.is_rsvd    = (r_type == REQ_RSVD);
        o_sts.count_zero = (r_count == '0);
        o_sts.idx_last   = ((CW'(r_idx) + CW'(1)) == r_count);
        o_sts.match      = (rd_data[ENT_W-1:MAC_W] == r_ip);
        o_sts.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip <= '0;
        end else if (i_cfg_wr_en) begin
            r_local_ip <= i_cfg_wr_data;
        end
    end

    // request capture and scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type  <= i_req_type;
            r_ip    <= i_ip_addr;
            r_mac   <= i_hw_addr;
            r_reply <= (i_req_type == REQ_PACKET) && (i_arp_opcode == OPC_REQUEST)
                       && (i_packet_target_ip == r_local_ip);
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.inc_idx) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.set_found) begin
                r_found     <= 1'b1;
                r_found_mac <= rd_data[MAC_W-1:0];
            end
        end
    end

    // valid entries always occupy slots below the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.wr_en && !r_found && !full) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_hit         <= is_lookup && r_found;
            r_o_found_mac <= (is_lookup && r_found) ? r_found_mac : '0;
            r_o_reply     <= r_reply;
            r_o_reply_ip  <= r_reply ? r_ip : '0;
            r_o_reply_mac <= r_reply ? r_mac : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_found_mac   = r_o_found_mac;
    assign o_reply_valid = r_o_reply;
    assign o_reply_ip    = r_o_reply_ip;
    assign o_reply_mac   = r_o_reply_mac;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT)
    `ASSERT_NEXT(a_rewrite_keeps_count, i_clk, i_rst_n, i_cmd.wr_en && r_found,
        r_count == $past(r_count))
    `ASSERT_ALWAYS(a_load_when_free, i_clk, i_rst_n, !i_cmd.out_load || out_free)
    `ASSERT_ALWAYS(a_hit_excl_reply, i_clk, i_rst_n, !(r_out_valid && r_hit && r_o_reply))

endmodule

`default_nettype wire

[src/arp_cache_table_engine.sv]
// ----------------------------------------------------------------------------
// arp_cache_table_engine
// ipv4 to mac binding table with insert, lookup and received packet learning
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall, a transfer carries one request
// (insert, lookup or received arp packet). output channel: o_out_valid /
// i_out_stall, one result transfer per request, in request order.
// config: i_cfg_wr_en / i_cfg_wr_data load local_ip, write only while idle.
// one request at a time: capture, setup, then an address step and a compare step per
// valid entry scanned through the table ram read port (stops on first match),
// a write step for learning requests and a final step to load the result.
// reserved request types skip the scan and write steps.
// a result waits in the output register under stall; the next request is
// accepted meanwhile and holds in its last step until the register frees.
// reset clears local_ip, the fill count and all handshake state; the table
// needs no clearing pass since valid entries are those below the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_table_engine #(
    parameter int ENTRIES = arpc_pkg::DEF_ENTRIES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [arpc_pkg::IP_W-1:0]   i_cfg_wr_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [1:0]                  i_req_type,
    input  wire logic [arpc_pkg::IP_W-1:0]   i_ip_addr,
    input  wire logic [arpc_pkg::MAC_W-1:0]  i_hw_addr,
    input  wire logic [arpc_pkg::OP_W-1:0]   i_arp_opcode,
    input  wire logic [arpc_pkg::IP_W-1:0]   i_packet_target_ip,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_hit,
    output logic [arpc_pkg::MAC_W-1:0]       o_found_mac,
    output logic                             o_reply_valid,
    output logic [arpc_pkg::IP_W-1:0]        o_reply_ip,
    output logic [arpc_pkg::MAC_W-1:0]       o_reply_mac
);

    import arpc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    arpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    arpc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_req_type         (i_req_type),
        .i_ip_addr          (i_ip_addr),
        .i_hw_addr          (i_hw_addr),
        .i_arp_opcode       (i_arp_opcode),
        .i_packet_target_ip (i_packet_target_ip),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_hit              (o_hit),
        .o_found_mac        (o_found_mac),
        .o_reply_valid      (o_reply_valid),
        .o_reply_ip         (o_reply_ip),
        .o_reply_mac        (o_reply_mac)
    );

endmodule

`default_nettype wire
